// File: sv/uart_baud_divisor_calc_unit_assert.svh
// Assertion macros used by the checker file of the baud divisor unit.
`ifndef UART_BAUD_DIVISOR_CALC_UNIT_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while rst is high.
`define UBDC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ubdc assertion failed");

// Next-cycle implication, skipped while rst is high.
`define UBDC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ubdc assertion failed");

`endif

// File: sv/ubdc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, types and helper functions of the baud divisor unit.
package ubdc_pkg;

   localparam int OSC_W         = 27;
   localparam int BAUD_W        = 20;
   localparam int NUM_W         = 34;           // osc*100 + 8*baud
   localparam int Q_W           = NUM_W - 4;    // dividend after dropping the x16
   localparam int DIV_W         = 16;
   localparam int DIG_W         = 4;
   localparam int ST_W          = 2;
   localparam int SCALE         = 100;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [OSC_W-1:0] OSC_RESET = OSC_W'(11059200);
   localparam int unsigned FALLBACK_BAUD_DEF = 9600;

   // Ratio limits: integer part must be 1..65536.
   localparam logic [Q_W-1:0] RATIO_MIN = Q_W'(100);
   localparam logic [Q_W-1:0] RATIO_LIM = Q_W'(6553700);

   // Divide by 100 through a reciprocal, exact for ratios below RATIO_LIM.
   localparam int RATIO_KEEP_W = 23;
   localparam int RECIP_W      = 24;
   localparam int RECIP_SHIFT  = 30;
   localparam int PROD_W       = RATIO_KEEP_W + RECIP_W;
   localparam int INT_W        = PROD_W - RECIP_SHIFT;
   localparam int REM_W        = 7;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(10737419);

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_FALLBACK = 2'd1;
   localparam logic [ST_W-1:0] ST_FAIL     = 2'd2;

   typedef struct packed {
      logic              bad;
      logic [BAUD_W-1:0] baud;
      logic [Q_W-1:0]    num;
   } item_type;

   typedef struct packed {
      logic             ok;
      logic [DIV_W-1:0] div;
      logic [DIG_W-1:0] digit;
   } fields_type;

   // (osc*100 + 8*baud) / 16, rounded down; the quotient by baud is then ratio_x100.
   function automatic logic [Q_W-1:0] scaled_num(input logic [OSC_W-1:0] osc,
                                                 input logic [BAUD_W-1:0] baud);
      logic [NUM_W-1:0] sum;
      sum = NUM_W'(osc) * NUM_W'(SCALE) + (NUM_W'(baud) << 3);
      return sum[NUM_W-1:4];
   endfunction

   // Tens digit of a value 0..99.
   function automatic logic [DIG_W-1:0] tens_digit(input logic [REM_W-1:0] rem);
      logic [DIG_W-1:0] d;
      d = '0;
      for (int i = 1; i < 10; i++) begin
         if (rem >= REM_W'(i * 10)) begin
            d = d + DIG_W'(1);
         end
      end
      return d;
   endfunction

endpackage

// File: sv/ubdc_fields.sv
`timescale 1ns / 1ps
// Two-stage split of ratio_x100 into divisor value, prescale digit and range flag.
module ubdc_fields (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_vld,
   input  logic [ubdc_pkg::Q_W-1:0]   in_ratio,
   output logic                       out_vld,
   output ubdc_pkg::fields_type       out_res
);
   import ubdc_pkg::*;

   logic                    vld1_ff;
   logic                    ok1_ff;
   logic [RATIO_KEEP_W-1:0] ratio1_ff;
   logic [PROD_W-1:0]       prod1_ff;
   logic                    vld2_ff;
   fields_type              res2_ff;

   logic [INT_W-1:0]        int_part;
   logic [RATIO_KEEP_W-1:0] int_x100;
   logic [RATIO_KEEP_W-1:0] rem_full;

   always_comb begin
      int_part = prod1_ff[PROD_W-1:RECIP_SHIFT];
      // x100 as 64 + 32 + 4
      int_x100 = RATIO_KEEP_W'({int_part, 6'b0}) + RATIO_KEEP_W'({int_part, 5'b0})
               + RATIO_KEEP_W'({int_part, 2'b0});
      rem_full = ratio1_ff - int_x100;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff    <= (in_ratio >= RATIO_MIN) && (in_ratio < RATIO_LIM);
      ratio1_ff <= in_ratio[RATIO_KEEP_W-1:0];
      prod1_ff  <= PROD_W'(in_ratio[RATIO_KEEP_W-1:0]) * PROD_W'(RECIP_100);
      res2_ff   <= '{ok:    ok1_ff,
                     div:   DIV_W'(int_part - INT_W'(1)),
                     digit: tens_digit(rem_full[REM_W-1:0])};
   end

   assign out_vld = vld2_ff;
   assign out_res = res2_ff;

endmodule

// File: sv/ubdc_front.sv
`timescale 1ns / 1ps
// Front end: accept a request, flag a zero baud and form the scaled dividend.
module ubdc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ubdc_pkg::BAUD_W-1:0]   req_baud_rate,
   input  logic [ubdc_pkg::OSC_W-1:0]    osc,
   input  logic                          fb_ready,
   input  logic                          q_full,
   output logic                          push,
   output ubdc_pkg::item_type            push_item
);
   import ubdc_pkg::*;

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   logic     take;

   assign push  = vld_ff && !q_full;
   assign busy  = !fb_ready || (vld_ff && q_full);
   assign take  = start && !busy;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{bad:  (req_baud_rate == '0),
                      baud: req_baud_rate,
                      num:  scaled_num(osc, req_baud_rate)};
      end
   end

   assign push_item = item_ff;

endmodule

// File: sv/ubdc_queue.sv
`timescale 1ns / 1ps
// Short queue between the front end and the divider pipeline.
module ubdc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ubdc_pkg::item_type  push_item,
   output logic                full,
   output logic                pop_vld,
   output ubdc_pkg::item_type  pop_item
);
   import ubdc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_vld  = (cnt_ff != '0);
   assign pop_item = mem[rd_ptr_ff];

   // The divider never stalls: pop whenever an entry is present.
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop_vld) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop_vld && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_vld) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/ubdc_fallback.sv
`timescale 1ns / 1ps
// Fallback divisor fields for the current oscillator setting, by reciprocal multiply.
module ubdc_fallback #(
   parameter int unsigned FALLBACK_BAUD = ubdc_pkg::FALLBACK_BAUD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic [ubdc_pkg::OSC_W-1:0]  osc,
   output logic                        fb_ready,
   output ubdc_pkg::fields_type        fb_res
);
   import ubdc_pkg::*;

   localparam logic [BAUD_W-1:0] FB_BAUD = BAUD_W'(FALLBACK_BAUD);

   // Reciprocal of the fallback rate, exact for every dividend below 2**Q_W.
   localparam int FB_SHIFT   = Q_W + $clog2(FALLBACK_BAUD);
   localparam int FB_RECIP_W = 32;
   localparam int FB_PROD_W  = Q_W + FB_RECIP_W;
   localparam logic [FB_RECIP_W-1:0] FB_RECIP =
      FB_RECIP_W'(((64'd1 << FB_SHIFT) + 64'(FALLBACK_BAUD) - 64'd1) / 64'(FALLBACK_BAUD));

   localparam logic [2:0] FB_LOAD   = 3'd0;
   localparam logic [2:0] FB_MUL    = 3'd1;
   localparam logic [2:0] FB_LAUNCH = 3'd2;
   localparam logic [2:0] FB_WAIT   = 3'd3;
   localparam logic [2:0] FB_DONE   = 3'd4;

   logic [2:0]           state_ff;
   logic [2:0]           state_in;
   logic [Q_W-1:0]       num_ff;
   logic [FB_PROD_W-1:0] prod_ff;
   fields_type           res_ff;

   logic [Q_W-1:0]       quot;
   logic                 fld_vld;
   fields_type           fld_res;

   assign quot = Q_W'(prod_ff >> FB_SHIFT);

   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in = FB_LOAD;
      end else begin
         case (state_ff)
            FB_LOAD:   state_in = FB_MUL;
            FB_MUL:    state_in = FB_LAUNCH;
            FB_LAUNCH: state_in = FB_WAIT;
            FB_WAIT: begin
               if (fld_vld) begin
                  state_in = FB_DONE;
               end
            end
            FB_DONE: state_in = FB_DONE;
            default: state_in = FB_LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FB_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FB_LOAD: begin
            num_ff <= scaled_num(osc, FB_BAUD);
         end
         FB_MUL: begin
            prod_ff <= FB_PROD_W'(num_ff) * FB_PROD_W'(FB_RECIP);
         end
         default: begin
         end
      endcase
      if ((state_ff == FB_WAIT) && fld_vld) begin
         res_ff <= fld_res;
      end
   end

   ubdc_fields u_fields (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (state_ff == FB_LAUNCH),
      .in_ratio (quot),
      .out_vld  (fld_vld),
      .out_res  (fld_res)
   );

   assign fb_ready = (state_ff == FB_DONE);
   assign fb_res   = res_ff;

endmodule

// File: sv/ubdc_back.sv
`timescale 1ns / 1ps
// Back end: pipelined restoring divider, field split and final status selection.
module ubdc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  ubdc_pkg::item_type            in_item,
   input  ubdc_pkg::fields_type          fb_res,
   output logic                          rsp_strobe,
   output logic [ubdc_pkg::DIV_W/2-1:0]  rsp_divisor_high,
   output logic [ubdc_pkg::DIV_W/2-1:0]  rsp_divisor_low,
   output logic [ubdc_pkg::DIG_W-1:0]    rsp_prescale_digit,
   output logic [ubdc_pkg::ST_W-1:0]     rsp_result_status
);
   import ubdc_pkg::*;

   localparam int BYTE_W = DIV_W / 2;

   logic              stg_vld_ff  [Q_W];
   item_type          stg_item_ff [Q_W];
   logic [BAUD_W-1:0] stg_rem_ff  [Q_W];
   logic [Q_W-1:0]    stg_quot_ff [Q_W];

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic              src_vld;
      item_type          src_item;
      logic [BAUD_W-1:0] src_rem;
      logic [Q_W-1:0]    src_quot;
      logic [BAUD_W:0]   rem_sh;
      logic [BAUD_W+1:0] diff;
      logic              take;

      if (k == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_item = in_item;
         assign src_rem  = '0;
         assign src_quot = '0;
      end else begin : g_next
         assign src_vld  = stg_vld_ff[k-1];
         assign src_item = stg_item_ff[k-1];
         assign src_rem  = stg_rem_ff[k-1];
         assign src_quot = stg_quot_ff[k-1];
      end

      always_comb begin
         rem_sh = {src_rem, src_item.num[Q_W-1-k]};
         diff   = {1'b0, rem_sh} - {2'b0, src_item.baud};
         take   = !diff[BAUD_W+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_vld_ff[k] <= 1'b0;
         end else begin
            stg_vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         stg_item_ff[k] <= src_item;
         stg_rem_ff[k]  <= take ? diff[BAUD_W-1:0] : rem_sh[BAUD_W-1:0];
         stg_quot_ff[k] <= {src_quot[Q_W-2:0], take};
      end
   end

   logic       fld_vld;
   fields_type fld_res;
   logic       bad1_ff;
   logic       bad2_ff;

   ubdc_fields u_fields (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (stg_vld_ff[Q_W-1]),
      .in_ratio (stg_quot_ff[Q_W-1]),
      .out_vld  (fld_vld),
      .out_res  (fld_res)
   );

   // Carry the zero-baud flag alongside the field split.
   always_ff @(posedge clock) begin
      bad1_ff <= stg_item_ff[Q_W-1].bad;
      bad2_ff <= bad1_ff;
   end

   logic              strobe_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [DIG_W-1:0]  digit_ff;
   logic [ST_W-1:0]   status_ff;
   logic [DIV_W-1:0]  div_in;
   logic [DIG_W-1:0]  digit_in;
   logic [ST_W-1:0]   status_in;

   always_comb begin
      if (!bad2_ff && fld_res.ok) begin
         div_in    = fld_res.div;
         digit_in  = fld_res.digit;
         status_in = ST_OK;
      end else if (fb_res.ok) begin
         div_in    = fb_res.div;
         digit_in  = fb_res.digit;
         status_in = ST_FALLBACK;
      end else begin
         div_in    = '0;
         digit_in  = '0;
         status_in = ST_FAIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fld_vld;
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      digit_ff  <= digit_in;
      status_ff <= status_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_divisor_high   = div_ff[DIV_W-1:BYTE_W];
   assign rsp_divisor_low    = div_ff[BYTE_W-1:0];
   assign rsp_prescale_digit = digit_ff;
   assign rsp_result_status  = status_ff;

endmodule

// File: sv/uart_baud_divisor_calc_unit.sv
`timescale 1ns / 1ps
// Top level of the UART baud divisor calculator.
// A taken request reaches rsp_strobe via the front register, queue, divider and field split.
// Throughput: one request per cycle while busy is low; the divider is a 30-stage pipeline,
// one quotient bit each. Reset: busy stays high through reset and after it while the fallback
// fields are computed; every csr write restarts that computation and raises busy again.
// Results are presented for exactly one cycle; the receiver cannot stall them.
module uart_baud_divisor_calc_unit #(
   parameter int unsigned FALLBACK_BAUD = ubdc_pkg::FALLBACK_BAUD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ubdc_pkg::BAUD_W-1:0]     req_baud_rate,
   input  logic                            csr_wr_en,
   input  logic [ubdc_pkg::OSC_W-1:0]      csr_wr_data,
   output logic                            rsp_strobe,
   output logic [ubdc_pkg::DIV_W/2-1:0]    rsp_divisor_high,
   output logic [ubdc_pkg::DIV_W/2-1:0]    rsp_divisor_low,
   output logic [ubdc_pkg::DIG_W-1:0]      rsp_prescale_digit,
   output logic [ubdc_pkg::ST_W-1:0]       rsp_result_status
);
   import ubdc_pkg::*;

   // Oscillator frequency register; user must write only while no beat is in flight; unchecked.
   logic [OSC_W-1:0] osc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         osc_ff <= OSC_RESET;
      end else if (csr_wr_en) begin
         osc_ff <= csr_wr_data;
      end
   end

   // The fallback result depends on the oscillator alone, so keep it ready
   // in a side unit instead of retrying each failed request.
   logic       fb_ready;
   fields_type fb_res;

   ubdc_fallback #(
      .FALLBACK_BAUD (FALLBACK_BAUD)
   ) u_fallback (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr_en),
      .osc      (osc_ff),
      .fb_ready (fb_ready),
      .fb_res   (fb_res)
   );

   // Front end: take a beat, flag a zero baud, form (osc*100 + 8*baud)/16.
   logic     push;
   item_type push_item;
   logic     q_full;

   ubdc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_baud_rate (req_baud_rate),
      .osc           (osc_ff),
      .fb_ready      (fb_ready),
      .q_full        (q_full),
      .push          (push),
      .push_item     (push_item)
   );

   // Decouple the front end from the divider pipeline.
   logic     pop_vld;
   item_type pop_item;

   ubdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop_vld   (pop_vld),
      .pop_item  (pop_item)
   );

   // Back end: divide by baud, split fields, pick ok / fallback / fail.
   ubdc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_vld             (pop_vld),
      .in_item            (pop_item),
      .fb_res             (fb_res),
      .rsp_strobe         (rsp_strobe),
      .rsp_divisor_high   (rsp_divisor_high),
      .rsp_divisor_low    (rsp_divisor_low),
      .rsp_prescale_digit (rsp_prescale_digit),
      .rsp_result_status  (rsp_result_status)
   );

endmodule

// File: sv/ubdc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the baud divisor unit and its bind.
`include "uart_baud_divisor_calc_unit_assert.svh"

module ubdc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [ubdc_pkg::BAUD_W-1:0]     req_baud_rate,
   input logic                            csr_wr_en,
   input logic                            rsp_strobe,
   input logic [ubdc_pkg::DIV_W/2-1:0]    rsp_divisor_high,
   input logic [ubdc_pkg::DIV_W/2-1:0]    rsp_divisor_low,
   input logic [ubdc_pkg::DIG_W-1:0]      rsp_prescale_digit,
   input logic [ubdc_pkg::ST_W-1:0]       rsp_result_status
);
   import ubdc_pkg::*;

   // A failed beat carries all-zero fields.
   `UBDC_ASSERT_IMP(a_fail_zero, clock, reset, rsp_strobe && (rsp_result_status == ST_FAIL), (rsp_divisor_high == '0) && (rsp_divisor_low == '0) && (rsp_prescale_digit == '0))

   // Prescale is a decimal digit and the status is a known code.
   `UBDC_ASSERT_IMP(a_digit_status, clock, reset, rsp_strobe, (rsp_prescale_digit <= DIG_W'(9)) && ((rsp_result_status == ST_OK) || (rsp_result_status == ST_FALLBACK) || (rsp_result_status == ST_FAIL)))

   // A zero baud never comes back as ok in the result beat for that request.
   `UBDC_ASSERT_IMP(a_zero_baud, clock, reset, start && !busy && (req_baud_rate == '0), ##35 (rsp_strobe && (rsp_result_status != ST_OK)))

   // Reset leaves the unit busy with no result showing.
   `UBDC_ASSERT_NXT(a_reset_busy, clock, 1'b0, reset, busy && !rsp_strobe)

   // A csr write restarts the fallback computation and blocks requests.
   `UBDC_ASSERT_NXT(a_csr_busy, clock, 1'b0, csr_wr_en, busy)

endmodule

bind uart_baud_divisor_calc_unit ubdc_checker u_ubdc_checker (.*);

// File: tb/sv/uart_baud_divisor_calc_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the UART baud divisor calculator: directed and random rates.
module uart_baud_divisor_calc_unit_tb;
   import ubdc_pkg::*;

   // One result beat as the block presents it.
   typedef struct packed {
      logic [7:0]       div_high;
      logic [7:0]       div_low;
      logic [DIG_W-1:0] digit;
      logic [ST_W-1:0]  status;
   } divisor_word_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [BAUD_W-1:0]   req_baud_rate;
   logic                csr_wr_en;
   logic [OSC_W-1:0]    csr_wr_data;
   logic                rsp_strobe;
   logic [7:0]          rsp_divisor_high;
   logic [7:0]          rsp_divisor_low;
   logic [DIG_W-1:0]    rsp_prescale_digit;
   logic [ST_W-1:0]     rsp_result_status;

   // Local copy of the oscillator register, updated on every csr write.
   logic [OSC_W-1:0]    osc_setting;
   // Divisor words predicted for accepted requests, oldest first.
   divisor_word_type    pending_divisors[$];
   int unsigned         mismatch_count = 0;
   int unsigned         burst_left = 0;

   uart_baud_divisor_calc_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_baud_rate      (req_baud_rate),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_divisor_high   (rsp_divisor_high),
      .rsp_divisor_low    (rsp_divisor_low),
      .rsp_prescale_digit (rsp_prescale_digit),
      .rsp_result_status  (rsp_result_status)
   );

   // 10 ns clock: rising edges at 5, 15, 25 ...
   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Try one baud rate: round osc*100/(16*baud) half up, keep integer parts 1..65536.
   function automatic bit divisor_fits(input longint unsigned osc, input longint unsigned baud,
                                       output logic [15:0] div, output logic [DIG_W-1:0] digit);
      longint unsigned denom;
      longint unsigned ratio_x100;
      longint unsigned whole;
      div = '0;
      digit = '0;
      if (baud == 0) begin
         return 1'b0;
      end
      denom = baud * 16;
      ratio_x100 = (osc * 100 + denom / 2) / denom;
      whole = ratio_x100 / 100;
      if (whole == 0 || whole > 64'h10000) begin
         return 1'b0;
      end
      div = 16'(whole - 1);
      digit = DIG_W'((ratio_x100 / 10) % 10);
      return 1'b1;
   endfunction

   // Full prediction: requested rate first, then the fallback rate, then all-zero failure.
   function automatic divisor_word_type predict_divisor(input logic [OSC_W-1:0] osc,
                                                        input logic [BAUD_W-1:0] baud);
      logic [15:0]      div;
      logic [DIG_W-1:0] digit;
      divisor_word_type word;
      bit               req_ok;
      bit               fb_ok;
      req_ok = divisor_fits(osc, baud, div, digit);
      if (req_ok) begin
         word.status = ST_OK;
      end else begin
         fb_ok = divisor_fits(osc, FALLBACK_BAUD_DEF, div, digit);
         if (fb_ok) begin
            word.status = ST_FALLBACK;
         end else begin
            div = '0;
            digit = '0;
            word.status = ST_FAIL;
         end
      end
      word.div_high = div[15:8];
      word.div_low  = div[7:0];
      word.digit    = digit;
      return word;
   endfunction

   // Common UART rates; random stimulus draws from them often.
   function automatic int unsigned std_rate(input int unsigned idx);
      case (idx)
         0:       return 300;
         1:       return 600;
         2:       return 1200;
         3:       return 2400;
         4:       return 4800;
         5:       return 9600;
         6:       return 14400;
         7:       return 19200;
         8:       return 38400;
         9:       return 57600;
         10:      return 115200;
         11:      return 230400;
         12:      return 460800;
         default: return 921600;
      endcase
   endfunction

   // Pick a rate: mostly servable for the current oscillator, some zero, some noise,
   // some just past the point where the integer part drops to zero.
   function automatic logic [BAUD_W-1:0] random_rate();
      longint unsigned top;
      longint unsigned bottom;
      top = osc_setting / 16;
      bottom = osc_setting / (16 * 65536) + 1;
      if (top > 64'hFFFFF) begin
         top = 64'hFFFFF;
      end
      if (top < bottom) begin
         top = bottom;
      end
      case ($urandom_range(0, 9))
         0:          return '0;
         1, 2, 3, 4: return BAUD_W'(std_rate($urandom_range(0, 13)));
         5, 6, 7:    return BAUD_W'($urandom_range(32'(bottom), 32'(top)));
         8:          return BAUD_W'(top + $urandom_range(0, 32'(top / 100) + 1));
         default:    return BAUD_W'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every result beat with the oldest prediction; results cannot be held off,
   // so sample at each rising edge the strobe is high.
   always @(posedge clock) begin : check_results
      divisor_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_divisors.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                     rsp_divisor_high, rsp_divisor_low, rsp_prescale_digit,
                     rsp_result_status);
            mismatch_count++;
         end else begin
            want = pending_divisors.pop_front();
            check_field("divisor_high", want.div_high, rsp_divisor_high);
            check_field("divisor_low", want.div_low, rsp_divisor_low);
            check_field("prescale_digit", want.digit, rsp_prescale_digit);
            check_field("result_status", want.status, rsp_result_status);
         end
      end
   end

   // Drop start and hold the sender off for a number of edges.
   task automatic hold_sender(input int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Burst pacing: random burst lengths, short gaps mostly, now and then a gap long
   // enough to land anywhere in the divider pipeline.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if ($urandom_range(0, 3) == 0) begin
            hold_sender($urandom_range(8, 40));
         end else begin
            hold_sender($urandom_range(1, 4));
         end
      end
   endtask

   // Send one request beat; start stays high until the block takes it.
   task automatic send_rate(input logic [BAUD_W-1:0] baud);
      @(negedge clock);
      start <= 1'b1;
      req_baud_rate <= baud;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_divisors.push_back(predict_divisor(osc_setting, baud));
      pace_sender();
   endtask

   // Drop start and wait for every predicted result to come back.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_divisors.size() != 0) @(posedge clock);
   endtask

   // Write the oscillator register with the block idle; the write restarts the
   // fallback computation, which the next send waits out through busy.
   task automatic write_osc(input logic [OSC_W-1:0] value);
      drain_results();
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      osc_setting = value;
   endtask

   // Reset oscillator value: zero rate, extreme rates, exact ratios, int part near one.
   task automatic test_reset_frequency();
      send_rate('0);
      send_rate(BAUD_W'(1));
      send_rate('1);
      send_rate(BAUD_W'(9600));
      send_rate(BAUD_W'(115200));
      send_rate(BAUD_W'(300));
      send_rate(BAUD_W'(460800));
      send_rate(BAUD_W'(691200));
      send_rate(BAUD_W'(691201));
      send_rate(BAUD_W'(921600));
      send_rate(BAUD_W'('hAAAAA));
      send_rate(BAUD_W'('h55555));
   endtask

   // Integer part at the top: exactly 65536, 65536 with digit 9, and one past.
   task automatic test_divisor_limits();
      write_osc(OSC_W'(1048576));
      send_rate(BAUD_W'(1));
      send_rate(BAUD_W'(2));
      write_osc(OSC_W'(1048591));
      send_rate(BAUD_W'(1));
      write_osc(OSC_W'(1048592));
      send_rate(BAUD_W'(1));
   endtask

   // Oscillator values at which the fallback rate fails as well.
   task automatic test_fallback_failure();
      write_osc('0);
      send_rate('0);
      send_rate(BAUD_W'(9600));
      send_rate(BAUD_W'(1));
      write_osc(OSC_W'(100000));
      send_rate(BAUD_W'(9600));
      send_rate(BAUD_W'(1));
      send_rate('0);
   endtask

   // Oscillator at the low and high ends of its range and at the all-ones value.
   task automatic test_frequency_extremes();
      write_osc(OSC_W'(1000000));
      send_rate(BAUD_W'(9600));
      send_rate(BAUD_W'(115200));
      write_osc(OSC_W'(100000000));
      send_rate(BAUD_W'(300));
      send_rate(BAUD_W'(9600));
      send_rate('1);
      write_osc('1);
      send_rate(BAUD_W'(1));
      send_rate(BAUD_W'(300));
   endtask

   // Random phases: a fresh oscillator value each phase, sometimes any 27-bit value.
   task automatic test_random_rates();
      int unsigned phase;
      for (phase = 0; phase < 8; phase++) begin
         if (phase % 4 == 3) begin
            write_osc(OSC_W'($urandom));
         end else begin
            write_osc(OSC_W'($urandom_range(1000000, 100000000)));
         end
         repeat (92) send_rate(random_rate());
      end
   endtask

   initial begin
      // Drive every input to a known value from time zero.
      reset = 1'b1;
      start = 1'b0;
      req_baud_rate = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      osc_setting = OSC_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_frequency();
      test_divisor_limits();
      test_fallback_failure();
      test_frequency_extremes();
      test_random_rates();

      // Let the pipeline flush, then watch for stray beats past the latency.
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Generous bound on the whole run.
   initial begin
      #(4_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
